[hw/rtl/positional_list_engine_assert.svh]
// Assertion macros shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PLE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/ple_pkg.sv]
// Package with the opcodes, status codes and sizes of the list engine.
package ple_pkg;
    localparam int unsigned CapacityDefault  = 32;
    localparam int unsigned DataWidthDefault = 32;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_READ_ALL  = 3'd6,
        OP_NOP       = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;
endpackage

[hw/rtl/ple_free_map.sv]
// Free map of list slots: finds the lowest free slot and tracks occupancy.
module ple_free_map #(
    parameter int unsigned CAPACITY = ple_pkg::CapacityDefault,
    localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_set,
    input  logic          i_clr,
    input  logic [SW-1:0] i_slot,
    output logic [SW-1:0] o_free_slot
);
    logic [CAPACITY-1:0] r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (i_set) r_used[i_slot] <= 1'b1;
            if (i_clr) r_used[i_slot] <= 1'b0;
        end
    end

    always_comb begin
        o_free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) o_free_slot = SW'(i);
        end
    end
endmodule

[hw/rtl/positional_list_engine.sv]
// Top level of the positional doubly linked list engine.
//  channel | direction | fields
//  input   | in        | op, value, position
//  result  | out       | status, element, index, last
// Inserts and deletes at either end go straight to the end slot; positional ones walk
// one link at a time, up to CAPACITY, through the single-port link memories.
// A readout gives one result per element, one memory read each, while the output is not stalled.
// Reset is synchronous; link and value memories are not cleared.
// A stalled result holds the sequencer; one item is handled at a time.
`include "positional_list_engine_assert.svh"
module positional_list_engine #(
    parameter int unsigned CAPACITY   = ple_pkg::CapacityDefault,
    parameter int unsigned DATA_WIDTH = ple_pkg::DataWidthDefault,
    localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_op,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic [5:0]                   i_position,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic signed [DATA_WIDTH-1:0] o_element,
    output logic [5:0]                   o_index,
    output logic                         o_last
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WALK  = 8'b0000_0010,
        S_WDATA = 8'b0000_0100,
        S_LINK  = 8'b0000_1000,
        S_FIX   = 8'b0001_0000,
        S_RDREQ = 8'b0010_0000,
        S_RDOUT = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [DATA_WIDTH-1:0] r_val_mem [CAPACITY];
    logic [SW-1:0] r_nxt_mem [CAPACITY];
    logic [SW-1:0] r_prv_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_val_q;
    logic [SW-1:0] r_nxt_q, r_prv_q;

    logic [SW-1:0] r_head, r_tail, r_cur, r_new;
    logic [CW-1:0] r_count;
    logic [6:0] r_pos, r_step;
    logic r_ins;
    logic [DATA_WIDTH-1:0] r_value;

    logic r_ovalid;
    logic [1:0] r_ostatus;
    logic [DATA_WIDTH-1:0] r_oelem;
    logic [5:0] r_oindex;
    logic r_olast;

    logic [SW-1:0] free_slot;
    logic fm_set, fm_clr;
    logic [SW-1:0] fm_slot;

    logic rd_en;
    logic [SW-1:0] rd_addr;
    logic wv_en, wn_en, wp_en;
    logic [SW-1:0] wv_addr, wn_addr, wp_addr;
    logic [SW-1:0] wn_data, wp_data;

    always_ff @(posedge i_clk) begin
        if (wv_en) r_val_mem[wv_addr] <= r_value;
        if (wn_en) r_nxt_mem[wn_addr] <= wn_data;
        if (wp_en) r_prv_mem[wp_addr] <= wp_data;
        if (rd_en) begin
            r_val_q <= r_val_mem[rd_addr];
            r_nxt_q <= r_nxt_mem[rd_addr];
            r_prv_q <= r_prv_mem[rd_addr];
        end
    end

    ple_free_map #(.CAPACITY(CAPACITY)) u_free (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_set      (fm_set),
        .i_clr      (fm_clr),
        .i_slot     (fm_slot),
        .o_free_slot(free_slot)
    );

    wire accept = i_valid && o_ready;
    wire out_free = !r_ovalid || i_ready;
    wire [6:0] cnt7 = 7'(r_count);
    wire [6:0] ipos = 7'(i_position);
    wire walking_done = (r_step == r_pos);

    assign o_ready   = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid   = r_ovalid;
    assign o_status  = r_ostatus;
    assign o_element = r_oelem;
    assign o_index   = r_oindex;
    assign o_last    = r_olast;

    // Control registers and result register.
    logic n_ovalid;
    logic [1:0] n_ostatus;
    logic [DATA_WIDTH-1:0] n_oelem;
    logic [5:0] n_oindex;
    logic n_olast;
    logic [SW-1:0] n_head, n_tail, n_cur, n_new;
    logic [CW-1:0] n_count;
    logic [6:0] n_pos, n_step;
    logic n_ins;
    logic [DATA_WIDTH-1:0] n_value;

    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && !i_ready;
        n_ostatus = r_ostatus;
        n_oelem = r_oelem;
        n_oindex = r_oindex;
        n_olast = r_olast;
        n_head = r_head;
        n_tail = r_tail;
        n_cur = r_cur;
        n_new = r_new;
        n_count = r_count;
        n_pos = r_pos;
        n_step = r_step;
        n_ins = r_ins;
        n_value = r_value;
        rd_en = 1'b0;
        rd_addr = r_cur;
        wv_en = 1'b0;
        wn_en = 1'b0;
        wp_en = 1'b0;
        wv_addr = r_new;
        wn_addr = r_new;
        wp_addr = r_new;
        wn_data = r_new;
        wp_data = r_new;
        fm_set = 1'b0;
        fm_clr = 1'b0;
        fm_slot = r_new;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_value = i_value;
                    n_ostatus = ple_pkg::ST_OK;
                    n_oelem = '0;
                    n_oindex = '0;
                    n_olast = 1'b1;
                    n_step = 7'd1;
                    n_cur = r_head;
                    n_state = S_OUT;
                    priority if (i_op <= ple_pkg::OP_INS_POS) begin
                        n_ins = 1'b1;
                        n_pos = (i_op == ple_pkg::OP_INS_FRONT) ? 7'd1 :
                                (i_op == ple_pkg::OP_INS_BACK) ? cnt7 + 7'd1 : ipos;
                        n_new = free_slot;
                        if (cnt7 >= 7'(CAPACITY)) begin
                            n_ostatus = ple_pkg::ST_FULL;
                        end else if (n_pos < 7'd1 || n_pos > cnt7 + 7'd1) begin
                            n_ostatus = ple_pkg::ST_BADPOS;
                        end else begin
                            n_state = S_WDATA;
                        end
                    end else if (i_op <= ple_pkg::OP_READ_ALL) begin
                        n_ins = 1'b0;
                        n_pos = (i_op == ple_pkg::OP_DEL_FRONT) ? 7'd1 :
                                (i_op == ple_pkg::OP_DEL_BACK) ? cnt7 : ipos;
                        if (r_count == '0) begin
                            n_ostatus = ple_pkg::ST_EMPTY;
                        end else if (i_op == ple_pkg::OP_READ_ALL) begin
                            n_state = S_RDREQ;
                        end else if (n_pos < 7'd1 || n_pos > cnt7) begin
                            n_ostatus = ple_pkg::ST_BADPOS;
                        end else if (n_pos == cnt7) begin
                            n_cur = r_tail;
                            n_step = n_pos;
                            n_state = S_WALK;
                        end else begin
                            n_state = S_WALK;
                        end
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_WDATA: begin
                // Store the value, claim the slot, then find the neighbour if the list is not empty.
                wv_en = 1'b1;
                fm_set = 1'b1;
                if (r_count == '0) begin
                    wn_en = 1'b1;
                    wp_en = 1'b1;
                    n_head = r_new;
                    n_tail = r_new;
                    n_count = r_count + CW'(1);
                    n_state = S_OUT;
                end else if (r_pos == 7'd1) begin
                    wn_en = 1'b1;
                    wn_data = r_head;
                    wp_en = 1'b1;
                    n_state = S_FIX;
                end else if (r_pos == cnt7 + 7'd1) begin
                    wn_en = 1'b1;
                    wp_en = 1'b1;
                    wp_data = r_tail;
                    n_state = S_FIX;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // One link per visit: read the current slot's links.
                rd_en = 1'b1;
                rd_addr = r_cur;
                n_state = S_LINK;
            end
            S_LINK: begin
                if (!walking_done) begin
                    n_cur = r_nxt_q;
                    n_step = r_step + 7'd1;
                    n_state = S_WALK;
                end else if (r_ins) begin
                    wn_en = 1'b1;
                    wn_data = r_cur;
                    wp_en = 1'b1;
                    wp_data = r_prv_q;
                    n_state = S_FIX;
                end else begin
                    n_oelem = r_val_q;
                    n_oindex = 6'(r_pos);
                    fm_clr = 1'b1;
                    fm_slot = r_cur;
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                        n_state = S_OUT;
                    end else if (r_pos == 7'd1) begin
                        n_head = r_nxt_q;
                        wp_en = 1'b1;
                        wp_addr = r_nxt_q;
                        wp_data = r_nxt_q;
                        n_state = S_OUT;
                    end else if (r_pos == cnt7) begin
                        n_tail = r_prv_q;
                        wn_en = 1'b1;
                        wn_addr = r_prv_q;
                        wn_data = r_prv_q;
                        n_state = S_OUT;
                    end else begin
                        wn_en = 1'b1;
                        wn_addr = r_prv_q;
                        wn_data = r_nxt_q;
                        wp_en = 1'b1;
                        wp_addr = r_nxt_q;
                        wp_data = r_prv_q;
                        n_state = S_OUT;
                    end
                end
            end
            S_FIX: begin
                // Link the neighbours to the new slot.
                n_count = r_count + CW'(1);
                n_state = S_OUT;
                if (r_pos == 7'd1) begin
                    wp_en = 1'b1;
                    wp_addr = r_head;
                    n_head = r_new;
                end else if (r_pos == cnt7 + 7'd1) begin
                    wn_en = 1'b1;
                    wn_addr = r_tail;
                    n_tail = r_new;
                end else begin
                    wn_en = 1'b1;
                    wn_addr = r_prv_q;
                    wp_en = 1'b1;
                    wp_addr = r_cur;
                end
            end
            S_RDREQ: begin
                if (out_free) begin
                    rd_en = 1'b1;
                    rd_addr = r_cur;
                    n_state = S_RDOUT;
                end
            end
            S_RDOUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostatus = ple_pkg::ST_OK;
                    n_oelem = r_val_q;
                    n_oindex = 6'(r_step);
                    n_olast = (r_step == cnt7);
                    n_cur = r_nxt_q;
                    n_step = r_step + 7'd1;
                    n_state = (r_step == cnt7) ? S_IDLE : S_RDREQ;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_head <= '0;
            r_tail <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_head <= n_head;
            r_tail <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ostatus <= n_ostatus;
        r_oelem <= n_oelem;
        r_oindex <= n_oindex;
        r_olast <= n_olast;
        r_cur <= n_cur;
        r_new <= n_new;
        r_pos <= n_pos;
        r_step <= n_step;
        r_ins <= n_ins;
        r_value <= n_value;
    end

    `PLE_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `PLE_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `PLE_ASSERT_NEXT(a_empty_heads, i_clk, i_rst_n, r_count == '0 && r_state == S_IDLE,
                     r_head == '0)
    `PLE_ASSERT_IMPL(a_status_elem, i_clk, i_rst_n, o_valid && o_status != ple_pkg::ST_OK,
                     o_element == '0 && o_index == '0)
endmodule

[tb/tb_top.sv]
// Self-checking testbench for the positional list engine, with scoreboard and stimulus.
`timescale 1ns / 1ps
module tb_top;
    localparam int Cap = 32;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [5:0]         index;
        logic               last;
    } t_result;

    class list_scoreboard;
        logic signed [31:0] entries[$];
        t_result            pending[$];
        int                 errors;
        int                 transfers;
        int                 results;

        function void push(logic [1:0] st, logic signed [31:0] el, int idx, bit lst);
            t_result r;
            r.status  = st;
            r.element = el;
            r.index   = idx[5:0];
            r.last    = lst;
            pending.push_back(r);
        endfunction

        function void note_transfer(logic [2:0] op, logic signed [31:0] val, logic [5:0] pos);
            int n;
            int p;
            logic signed [31:0] v;
            n = entries.size();
            transfers++;
            case (op)
                ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_POS: begin
                    p = (op == ple_pkg::OP_INS_FRONT) ? 1 :
                        (op == ple_pkg::OP_INS_BACK) ? n + 1 : int'(pos);
                    if (n >= Cap) begin
                        push(ple_pkg::ST_FULL, 0, 0, 1);
                    end else if (p < 1 || p > n + 1) begin
                        push(ple_pkg::ST_BADPOS, 0, 0, 1);
                    end else begin
                        entries.insert(p - 1, val);
                        push(ple_pkg::ST_OK, 0, 0, 1);
                    end
                end
                ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_POS: begin
                    p = (op == ple_pkg::OP_DEL_FRONT) ? 1 :
                        (op == ple_pkg::OP_DEL_BACK) ? n : int'(pos);
                    if (n == 0) begin
                        push(ple_pkg::ST_EMPTY, 0, 0, 1);
                    end else if (p < 1 || p > n) begin
                        push(ple_pkg::ST_BADPOS, 0, 0, 1);
                    end else begin
                        v = entries[p - 1];
                        entries.delete(p - 1);
                        push(ple_pkg::ST_OK, v, p, 1);
                    end
                end
                ple_pkg::OP_READ_ALL: begin
                    if (n == 0) begin
                        push(ple_pkg::ST_EMPTY, 0, 0, 1);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            push(ple_pkg::ST_OK, entries[i], i + 1, i == n - 1);
                        end
                    end
                end
                default: push(ple_pkg::ST_OK, 0, 0, 1);
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp;
            results++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result st=%0d el=%0d idx=%0d last=%0d", $time,
                         got.status, got.element, got.index, got.last);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.element !== exp.element) begin
                $display("%0t: element expected %0d actual %0d", $time, exp.element,
                         got.element);
                errors++;
            end
            if (got.index !== exp.index) begin
                $display("%0t: index expected %0d actual %0d", $time, exp.index, got.index);
                errors++;
            end
            if (got.last !== exp.last) begin
                $display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         in_op;
    logic signed [31:0] in_value;
    logic [5:0]         in_position;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         out_status;
    logic signed [31:0] out_element;
    logic [5:0]         out_index;
    logic               out_last;

    list_scoreboard sb;
    bit             hold_off;
    int             idle_cycles;

    positional_list_engine u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_ready    (in_ready),
        .i_op       (in_op),
        .i_value    (in_value),
        .i_position (in_position),
        .o_valid    (out_valid),
        .i_ready    (out_ready),
        .o_status   (out_status),
        .o_element  (out_element),
        .o_index    (out_index),
        .o_last     (out_last)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        sb = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_op       = ple_pkg::OP_NOP;
        in_value    = '0;
        in_position = '0;
        out_ready   = 1'b0;
    end

    // Receiver: stalls on its own pattern, with one long hold-off while the sender keeps going.
    initial begin
        int phase;
        phase = 0;
        @(posedge clk iff rst_n);
        forever begin
            @(posedge clk);
            phase++;
            if (hold_off) begin
                out_ready <= 1'b0;
            end else if ((phase / 64) % 2 == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge clk) begin
        t_result r;
        if (rst_n && out_valid && out_ready) begin
            r.status  = out_status;
            r.element = out_element;
            r.index   = out_index;
            r.last    = out_last;
            sb.check_result(r);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 3000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    int burst_left;

    task automatic send_item(logic [2:0] op, logic signed [31:0] val, logic [5:0] pos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        in_op       <= op;
        in_value    <= val;
        in_position <= pos;
        @(posedge clk iff in_ready);
        sb.note_transfer(op, val, pos);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n;
        int guard;
        logic [2:0] op;
        burst_left = 0;
        hold_off   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty list errors, value extremes, bad positions, readout.
        send_item(ple_pkg::OP_DEL_FRONT, 0, 1);
        send_item(ple_pkg::OP_READ_ALL, 0, 0);
        send_item(ple_pkg::OP_DEL_POS, 0, 1);
        send_item(ple_pkg::OP_INS_POS, 5, 0);
        send_item(ple_pkg::OP_INS_POS, 5, 2);
        send_item(ple_pkg::OP_INS_FRONT, 32'sh7fffffff, 0);
        send_item(ple_pkg::OP_INS_BACK, 32'sh80000000, 63);
        send_item(ple_pkg::OP_INS_POS, -1, 2);
        send_item(ple_pkg::OP_INS_POS, 7, 4);
        send_item(ple_pkg::OP_INS_POS, 9, 6);
        send_item(ple_pkg::OP_READ_ALL, 0, 0);
        send_item(ple_pkg::OP_DEL_POS, 0, 0);
        send_item(ple_pkg::OP_DEL_POS, 0, 5);
        send_item(ple_pkg::OP_DEL_POS, 0, 2);
        send_item(ple_pkg::OP_DEL_BACK, 0, 0);
        send_item(ple_pkg::OP_NOP, 32'sh5a5a5a5a, 6'h2a);
        send_item(ple_pkg::OP_DEL_FRONT, 0, 0);
        send_item(ple_pkg::OP_DEL_FRONT, 0, 0);
        send_item(ple_pkg::OP_DEL_BACK, 0, 0);
        send_item(ple_pkg::OP_READ_ALL, 0, 0);

        // Fill to capacity, overflow, then read out under a long receiver hold-off.
        for (int i = 0; i < Cap; i++) begin
            send_item((i % 2 != 0) ? ple_pkg::OP_INS_FRONT : ple_pkg::OP_INS_POS,
                      rand_value(), 6'($urandom_range(1, i + 1)));
        end
        send_item(ple_pkg::OP_INS_BACK, 1, 0);
        send_item(ple_pkg::OP_INS_POS, 1, 33);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_item(ple_pkg::OP_READ_ALL, 0, 0);
                send_item(ple_pkg::OP_DEL_POS, 0, 32);
                send_item(ple_pkg::OP_DEL_POS, 0, 33);
                send_item(ple_pkg::OP_READ_ALL, 0, 0);
            end
        join

        // Random part: biased towards a populated list.
        for (int k = 0; k < 52; k++) begin
            n = sb.entries.size();
            case ($urandom_range(0, 9))
                0, 1, 2: op = (n < 20) ? ple_pkg::OP_INS_POS : ple_pkg::OP_DEL_POS;
                3:       op = ple_pkg::OP_INS_FRONT;
                4:       op = ple_pkg::OP_INS_BACK;
                5:       op = ple_pkg::OP_DEL_FRONT;
                6:       op = ple_pkg::OP_DEL_BACK;
                7:       op = ple_pkg::OP_READ_ALL;
                8:       op = ple_pkg::OP_DEL_POS;
                default: op = 3'($urandom_range(0, 7));
            endcase
            send_item(op, rand_value(),
                      ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(1, n + 1)));
        end
        in_valid <= 1'b0;

        guard = 0;
        while (sb.pending.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        $display("Covered %0d transfers in and %0d results out, including full and empty lists,",
                 sb.transfers, sb.results);
        $display("bad positions, no-ops, value extremes and a long output stall.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
